@@ sv/particle_contact_resolver_macros.svh @@
// Assertion helpers for the contact resolver.
`ifndef PARTICLE_CONTACT_RESOLVER_MACROS_SVH
`define PARTICLE_CONTACT_RESOLVER_MACROS_SVH

// Same-cycle implication, reset masked.
`define PCR_ASSERT_IMP(name, ck, rst_n, pre, post, msg) \
	name: assert property (@(posedge ck) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, reset masked.
`define PCR_ASSERT_NEXT(name, ck, rst_n, pre, post, msg) \
	name: assert property (@(posedge ck) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

@@ sv/pcr_pkg.sv @@
`default_nettype none
package pcr_pkg;

	localparam int CW         = 21;   // one Q10.10 component
	localparam int VW         = 3 * CW;
	localparam int SEP_W      = 44;   // Q20.20 dot product
	localparam int DELTA_W    = 46;
	localparam int DIV_N      = 63;   // quotient bits, one per divider stage
	localparam int DEN_W      = 33;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;
	localparam int SEP_LIMIT  = -105;
	localparam int IMP_W      = 59;   // impulse clamped to 2^58
	localparam int IMP_LO_W   = 30;
	localparam int SHARE_W    = 43;   // share clamped to 2^42
	localparam int WIDE_W     = 48;
	localparam logic [15:0] DT_RESET = 16'd1092;

	typedef logic [VW-1:0]          vec_t;
	typedef logic signed [CW-1:0]   comp_t;
	typedef logic signed [CW:0]     comp_ext_t;
	typedef logic signed [2*CW:0]   dprod_t;
	typedef logic signed [SEP_W-1:0] sep_t;
	typedef logic signed [WIDE_W-1:0] wide_t;

	typedef struct packed {
		vec_t               va;
		vec_t               vb;
		vec_t               pa;
		vec_t               pb;
		vec_t               n;
		logic signed [31:0] pen;
		logic [16:0]        rest;
		logic [31:0]        inv_a;
		logic [31:0]        inv_b;
		logic [DEN_W-1:0]   total;
		logic               has;
	} item_t;

	// front -> back queue entry
	typedef struct packed {
		item_t item;
		sep_t  sep;
		sep_t  adot;
		logic  bounce;
		logic  push;
	} fbeat_t;

	// carried alongside the divider
	typedef struct packed {
		item_t item;
		logic  bounce;
		logic  push;
	} side_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	function automatic comp_t get_comp(vec_t w, int k);
		return w[CW*k +: CW];
	endfunction

	function automatic comp_ext_t ext_comp(vec_t w, int k);
		comp_t c;
		c = w[CW*k +: CW];
		return {c[CW-1], c};
	endfunction

	function automatic comp_t sat_comp(wide_t v);
		wide_t hi;
		wide_t lo;
		hi = wide_t'((2 ** (CW - 1)) - 1);
		lo = -wide_t'(2 ** (CW - 1));
		if (v > hi) return hi[CW-1:0];
		if (v < lo) return lo[CW-1:0];
		return v[CW-1:0];
	endfunction

	function automatic vec_t pack3(wide_t x, wide_t y, wide_t z);
		return {sat_comp(z), sat_comp(y), sat_comp(x)};
	endfunction

endpackage
`default_nettype wire

@@ sv/pcr_front.sv @@
`default_nettype none
module pcr_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  pcr_pkg::vec_t      vel_a,
	input  pcr_pkg::vec_t      vel_b,
	input  pcr_pkg::vec_t      acc_a,
	input  pcr_pkg::vec_t      acc_b,
	input  pcr_pkg::vec_t      pos_a,
	input  pcr_pkg::vec_t      pos_b,
	input  pcr_pkg::vec_t      contact_normal,
	input  logic signed [31:0] penetration_depth,
	input  logic [16:0]        restitution_coef,
	input  logic [31:0]        inv_mass_a,
	input  logic [31:0]        inv_mass_b,
	input  logic               has_partner,
	input  logic               fifo_full,
	output logic               fifo_wr,
	output pcr_pkg::fbeat_t    fifo_beat
);
	import pcr_pkg::*;

	logic      adv;
	logic      v_s1, v_s2;
	item_t     item_c, item_s1, item_s2;
	comp_ext_t rel_c [3];
	comp_ext_t arel_c [3];
	comp_ext_t rel_s1 [3];
	comp_ext_t arel_s1 [3];
	dprod_t    rp_s2 [3];
	dprod_t    ap_s2 [3];
	sep_t      sep_c, adot_c;

	// stall only when the last stage cannot drop into the queue
	assign adv      = !(v_s2 && fifo_full);
	assign in_ready = adv;

	always_comb begin
		item_c.va    = vel_a;
		item_c.vb    = vel_b;
		item_c.pa    = pos_a;
		item_c.pb    = pos_b;
		item_c.n     = contact_normal;
		item_c.pen   = penetration_depth;
		item_c.rest  = restitution_coef;
		item_c.inv_a = inv_mass_a;
		item_c.inv_b = inv_mass_b;
		item_c.has   = has_partner;
		item_c.total = {1'b0, inv_mass_a} + (has_partner ? {1'b0, inv_mass_b} : '0);
		for (int k = 0; k < 3; k++) begin
			rel_c[k]  = ext_comp(vel_a, k) - (has_partner ? ext_comp(vel_b, k) : '0);
			arel_c[k] = ext_comp(acc_a, k) - (has_partner ? ext_comp(acc_b, k) : '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= item_c;
			item_s2 <= item_s1;
			for (int k = 0; k < 3; k++) begin
				rel_s1[k]  <= rel_c[k];
				arel_s1[k] <= arel_c[k];
				rp_s2[k]   <= rel_s1[k] * get_comp(item_s1.n, k);
				ap_s2[k]   <= arel_s1[k] * get_comp(item_s1.n, k);
			end
		end
	end

	always_comb begin
		sep_c  = {rp_s2[0][2*CW], rp_s2[0]} + {rp_s2[1][2*CW], rp_s2[1]}
			+ {rp_s2[2][2*CW], rp_s2[2]};
		adot_c = {ap_s2[0][2*CW], ap_s2[0]} + {ap_s2[1][2*CW], ap_s2[1]}
			+ {ap_s2[2][2*CW], ap_s2[2]};
		fifo_beat.item   = item_s2;
		fifo_beat.sep    = sep_c;
		fifo_beat.adot   = adot_c;
		fifo_beat.bounce = (sep_c <= SEP_LIMIT) && (item_s2.total != '0);
		fifo_beat.push   = (item_s2.pen > 0) && (item_s2.total != '0);
	end

	assign fifo_wr = v_s2 && adv;

endmodule
`default_nettype wire

@@ sv/pcr_fifo.sv @@
`default_nettype none
module pcr_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr,
	input  pcr_pkg::fbeat_t     wr_beat,
	input  logic                rd,
	output pcr_pkg::fbeat_t     rd_beat,
	output pcr_pkg::fifo_stat_t stat
);
	import pcr_pkg::*;

	fbeat_t             mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_AW:0]   cnt_q;

	assign rd_beat    = mem_q[rd_ptr_q];
	assign stat.full  = (cnt_q == (FIFO_AW + 1)'(FIFO_DEPTH));
	assign stat.empty = (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (rd) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (wr && !rd) cnt_q <= cnt_q + 1'b1;
			else if (rd && !wr) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wr_ptr_q] <= wr_beat;
	end

endmodule
`default_nettype wire

@@ sv/pcr_div.sv @@
`default_nettype none
module pcr_div (
	input  logic                          clk,
	input  logic                          en,
	input  logic [pcr_pkg::DIV_N-1:0]     num,
	input  logic [pcr_pkg::DEN_W-1:0]     den,
	output logic [pcr_pkg::DIV_N-1:0]     quo,
	output logic [pcr_pkg::DEN_W-1:0]     rem
);
	import pcr_pkg::*;

	// restoring division, one quotient bit per stage
	logic [DIV_N-1:0] num_q [DIV_N];
	logic [DEN_W-1:0] rem_q [DIV_N];
	logic [DEN_W-1:0] den_q [DIV_N];
	logic [DIV_N-1:0] num_d [DIV_N];
	logic [DEN_W-1:0] rem_d [DIV_N];
	logic [DEN_W:0]   trial [DIV_N];
	logic             ge    [DIV_N];

	always_comb begin
		for (int k = 0; k < DIV_N; k++) begin
			if (k == 0) begin
				trial[k] = {{DEN_W{1'b0}}, num[DIV_N-1]};
				ge[k]    = trial[k] >= {1'b0, den};
				rem_d[k] = ge[k] ? DEN_W'(trial[k] - {1'b0, den}) : trial[k][DEN_W-1:0];
				num_d[k] = {num[DIV_N-2:0], ge[k]};
			end else begin
				trial[k] = {rem_q[k-1], num_q[k-1][DIV_N-1]};
				ge[k]    = trial[k] >= {1'b0, den_q[k-1]};
				rem_d[k] = ge[k] ? DEN_W'(trial[k] - {1'b0, den_q[k-1]})
					: trial[k][DEN_W-1:0];
				num_d[k] = {num_q[k-1][DIV_N-2:0], ge[k]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < DIV_N; k++) begin
				num_q[k] <= num_d[k];
				rem_q[k] <= rem_d[k];
				den_q[k] <= (k == 0) ? den : den_q[(k == 0) ? 0 : k - 1];
			end
		end
	end

	assign quo = num_q[DIV_N-1];
	assign rem = rem_q[DIV_N-1];

endmodule
`default_nettype wire

@@ sv/pcr_back.sv @@
`default_nettype none
module pcr_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [15:0]         dt_step,
	input  pcr_pkg::fifo_stat_t fifo_stat,
	input  pcr_pkg::fbeat_t     rd_beat,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output pcr_pkg::vec_t       new_vel_a,
	output pcr_pkg::vec_t       new_vel_b,
	output pcr_pkg::vec_t       new_pos_a,
	output pcr_pkg::vec_t       new_pos_b,
	output logic                bounce_applied,
	output logic                push_applied
);
	import pcr_pkg::*;

	logic adv;

	// stage 1: products for new separation, accel closing, penetration share
	logic               v_s1;
	side_t              side_s1;
	sep_t               sep_s1;
	logic [SEP_W+16:0]  nprod_s1;
	logic signed [SEP_W+16:0] aprod_s1;
	logic [DIV_N-1:0]   pprod_s1;
	logic [SEP_W-1:0]   negsep_c;

	// divider inputs
	logic [SEP_W:0]         newsep_raw, newsep_c;
	logic signed [SEP_W:0]  accsep_c;
	logic signed [SEP_W+1:0] nsum_c;
	logic [SEP_W+2:0]       delta_full;
	logic [DELTA_W-1:0]     delta_c;
	logic [DIV_N-1:0]       imp_num;
	logic [DIV_N-1:0]       imp_quo, pen_quo;
	logic [DEN_W-1:0]       imp_rem, pen_rem;

	side_t            sd_q [DIV_N];
	logic [DIV_N-1:0] vd_q;

	// stage 3: impulse split products, penetration shares
	logic                 v_s3;
	side_t                side_s3;
	logic [IMP_W-1:0]     imp_cl;
	logic [IMP_LO_W+31:0] plo_a_s3, plo_b_s3;
	logic [IMP_W-IMP_LO_W+31:0] phi_a_s3, phi_b_s3;
	logic [30:0]          ma_s3, mb_s3;
	side_t                side_last;

	// stage 4: shares
	logic                 v_s4;
	side_t                side_s4;
	logic [IMP_W+31:0]    full_a, full_b;
	logic [SHARE_W-1:0]   sa_s4, sb_s4;
	logic [30:0]          ma_s4, mb_s4;

	// stage 5: per-component deltas
	logic                     v_s5;
	side_t                    side_s5;
	logic signed [SHARE_W+CW+1:0] dva_s5 [3];
	logic signed [SHARE_W+CW+1:0] dvb_s5 [3];
	logic signed [CW+32:0]    dpa_s5 [3];
	logic signed [CW+32:0]    dpb_s5 [3];

	// output register
	logic  out_valid_q;
	vec_t  vel_a_q, vel_b_q, pos_a_q, pos_b_q;
	logic  bounce_q, push_q;
	wide_t va_w [3];
	wide_t vb_w [3];
	wide_t pa_w [3];
	wide_t pb_w [3];
	logic signed [SHARE_W+CW+1:0] shv_a [3];
	logic signed [SHARE_W+CW+1:0] shv_b [3];
	logic signed [CW+32:0]    shp_a [3];
	logic signed [CW+32:0]    shp_b [3];

	assign adv = !out_valid_q || out_ready;
	assign pop = adv && !fifo_stat.empty;

	assign negsep_c = -rd_beat.sep;

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1.item   <= rd_beat.item;
			side_s1.bounce <= rd_beat.bounce;
			side_s1.push   <= rd_beat.push;
			sep_s1         <= rd_beat.sep;
			nprod_s1       <= negsep_c * rd_beat.item.rest;
			aprod_s1       <= rd_beat.adot * $signed({1'b0, dt_step});
			pprod_s1       <= rd_beat.item.pen[30:0] * rd_beat.item.inv_a;
		end
	end

	// new separation: restitution term, minus accel closing, floored at zero
	always_comb begin
		newsep_raw = nprod_s1[SEP_W+16:16];
		accsep_c   = aprod_s1[SEP_W+16:16];
		nsum_c     = $signed({1'b0, newsep_raw}) + {accsep_c[SEP_W], accsep_c};
		if (accsep_c < 0) newsep_c = (nsum_c < 0) ? '0 : nsum_c[SEP_W:0];
		else newsep_c = newsep_raw;
		delta_full = {2'b00, newsep_c} - {{3{sep_s1[SEP_W-1]}}, sep_s1};
		delta_c    = delta_full[DELTA_W-1:0];
		imp_num    = {1'b0, delta_c, 16'b0};
	end

	pcr_div u_div_imp (
		.clk (clk),
		.en  (adv),
		.num (imp_num),
		.den (side_s1.item.total),
		.quo (imp_quo),
		.rem (imp_rem)
	);

	pcr_div u_div_pen (
		.clk (clk),
		.en  (adv),
		.num (pprod_s1),
		.den (side_s1.item.total),
		.quo (pen_quo),
		.rem (pen_rem)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < DIV_N; k++) sd_q[k] <= (k == 0) ? side_s1 : sd_q[(k == 0) ? 0 : k - 1];
		end
	end

	assign side_last = sd_q[DIV_N-1];

	always_comb begin
		imp_cl = (|imp_quo[DIV_N-1:IMP_W-1]) ? (IMP_W'(1) << (IMP_W - 1))
			: {1'b0, imp_quo[IMP_W-2:0]};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s3  <= side_last;
			plo_a_s3 <= imp_cl[IMP_LO_W-1:0] * side_last.item.inv_a;
			plo_b_s3 <= imp_cl[IMP_LO_W-1:0] * side_last.item.inv_b;
			phi_a_s3 <= imp_cl[IMP_W-1:IMP_LO_W] * side_last.item.inv_a;
			phi_b_s3 <= imp_cl[IMP_W-1:IMP_LO_W] * side_last.item.inv_b;
			ma_s3    <= pen_quo[30:0];
			// the two shares sum to pen, or pen - 1 when the division is inexact
			mb_s3    <= side_last.item.pen[30:0] - pen_quo[30:0] - {30'b0, |pen_rem};
		end
	end

	always_comb begin
		full_a = {phi_a_s3, {IMP_LO_W{1'b0}}} + {{(IMP_W - IMP_LO_W){1'b0}}, plo_a_s3};
		full_b = {phi_b_s3, {IMP_LO_W{1'b0}}} + {{(IMP_W - IMP_LO_W){1'b0}}, plo_b_s3};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s4 <= side_s3;
			sa_s4   <= (|full_a[IMP_W+31:SHARE_W+15]) ? (SHARE_W'(1) << (SHARE_W - 1))
				: full_a[SHARE_W+15:16];
			sb_s4   <= (|full_b[IMP_W+31:SHARE_W+15]) ? (SHARE_W'(1) << (SHARE_W - 1))
				: full_b[SHARE_W+15:16];
			ma_s4   <= ma_s3;
			mb_s4   <= mb_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s5 <= side_s4;
			for (int k = 0; k < 3; k++) begin
				dva_s5[k] <= ext_comp(side_s4.item.n, k) * $signed({1'b0, sa_s4});
				dvb_s5[k] <= (-ext_comp(side_s4.item.n, k)) * $signed({1'b0, sb_s4});
				dpa_s5[k] <= ext_comp(side_s4.item.n, k) * $signed({1'b0, ma_s4});
				dpb_s5[k] <= (-ext_comp(side_s4.item.n, k)) * $signed({1'b0, mb_s4});
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			shv_a[k] = dva_s5[k] >>> 20;
			shv_b[k] = dvb_s5[k] >>> 20;
			shp_a[k] = dpa_s5[k] >>> 16;
			shp_b[k] = dpb_s5[k] >>> 16;
			va_w[k]  = WIDE_W'(get_comp(side_s5.item.va, k)) + shv_a[k][WIDE_W-1:0];
			vb_w[k]  = WIDE_W'(get_comp(side_s5.item.vb, k)) + shv_b[k][WIDE_W-1:0];
			pa_w[k]  = WIDE_W'(get_comp(side_s5.item.pa, k)) + WIDE_W'(shp_a[k]);
			pb_w[k]  = WIDE_W'(get_comp(side_s5.item.pb, k)) + WIDE_W'(shp_b[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bounce_q <= side_s5.bounce;
			push_q   <= side_s5.push;
			vel_a_q  <= side_s5.bounce ? pack3(va_w[0], va_w[1], va_w[2]) : side_s5.item.va;
			vel_b_q  <= (side_s5.bounce && side_s5.item.has)
				? pack3(vb_w[0], vb_w[1], vb_w[2]) : side_s5.item.vb;
			pos_a_q  <= side_s5.push ? pack3(pa_w[0], pa_w[1], pa_w[2]) : side_s5.item.pa;
			pos_b_q  <= (side_s5.push && side_s5.item.has)
				? pack3(pb_w[0], pb_w[1], pb_w[2]) : side_s5.item.pb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			vd_q        <= '0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= pop;
			vd_q        <= {vd_q[DIV_N-2:0], v_s1};
			v_s3        <= vd_q[DIV_N-1];
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			out_valid_q <= v_s5;
		end
	end

	assign out_valid      = out_valid_q;
	assign new_vel_a      = vel_a_q;
	assign new_vel_b      = vel_b_q;
	assign new_pos_a      = pos_a_q;
	assign new_pos_b      = pos_b_q;
	assign bounce_applied = bounce_q;
	assign push_applied   = push_q;

endmodule
`default_nettype wire

@@ sv/particle_contact_resolver.sv @@
// Stages from an accepted input beat to out_valid (front stage 2, 1 queue slot,
//   1 product stage, 63 divider stages, 4 back stages). Throughput: one contact per
//   cycle unless out_ready stalls; each divider retires one quotient bit per stage.
// Reset: arst_n asynchronous, active low; clears all valid bits, queue pointers and
//   restores dt_step to 1092 (about 1/60 s). Payload registers are not reset.
`default_nettype none
`include "particle_contact_resolver_macros.svh"
module particle_contact_resolver (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [15:0]        cfg_wr_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  pcr_pkg::vec_t      vel_a,
	input  pcr_pkg::vec_t      vel_b,
	input  pcr_pkg::vec_t      acc_a,
	input  pcr_pkg::vec_t      acc_b,
	input  pcr_pkg::vec_t      pos_a,
	input  pcr_pkg::vec_t      pos_b,
	input  pcr_pkg::vec_t      contact_normal,
	input  logic signed [31:0] penetration_depth,
	input  logic [16:0]        restitution_coef,
	input  logic [31:0]        inv_mass_a,
	input  logic [31:0]        inv_mass_b,
	input  logic               has_partner,
	output logic               out_valid,
	input  logic               out_ready,
	output pcr_pkg::vec_t      new_vel_a,
	output pcr_pkg::vec_t      new_vel_b,
	output pcr_pkg::vec_t      new_pos_a,
	output pcr_pkg::vec_t      new_pos_b,
	output logic               bounce_applied,
	output logic               push_applied
);
	import pcr_pkg::*;

	// Front: relative velocity/accel, Q20.20 dot products with the normal,
	// bounce/push classification. Queue of four beats decouples it from the
	// back, which runs the impulse and penetration divisions and the updates.

	logic        [15:0] dt_step_q;
	logic               fifo_wr;
	fbeat_t             fifo_wbeat;
	fbeat_t             fifo_rbeat;
	fifo_stat_t         fifo_stat;
	logic               back_pop;

	// frame step register, write-only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_step_q <= DT_RESET;
		end else if (cfg_wr_en) begin
			dt_step_q <= cfg_wr_data;
		end
	end

	pcr_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.vel_a             (vel_a),
		.vel_b             (vel_b),
		.acc_a             (acc_a),
		.acc_b             (acc_b),
		.pos_a             (pos_a),
		.pos_b             (pos_b),
		.contact_normal    (contact_normal),
		.penetration_depth (penetration_depth),
		.restitution_coef  (restitution_coef),
		.inv_mass_a        (inv_mass_a),
		.inv_mass_b        (inv_mass_b),
		.has_partner       (has_partner),
		.fifo_full         (fifo_stat.full),
		.fifo_wr           (fifo_wr),
		.fifo_beat         (fifo_wbeat)
	);

	pcr_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (fifo_wr),
		.wr_beat (fifo_wbeat),
		.rd      (back_pop),
		.rd_beat (fifo_rbeat),
		.stat    (fifo_stat)
	);

	// Back: whole pipeline advances when the output register is free or taken.
	pcr_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.dt_step        (dt_step_q),
		.fifo_stat      (fifo_stat),
		.rd_beat        (fifo_rbeat),
		.pop            (back_pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.new_vel_a      (new_vel_a),
		.new_vel_b      (new_vel_b),
		.new_pos_a      (new_pos_a),
		.new_pos_b      (new_pos_b),
		.bounce_applied (bounce_applied),
		.push_applied   (push_applied)
	);

	// queue never written while full, never read while empty
	`PCR_ASSERT_IMP(a_fifo_no_overflow, clk, arst_n, fifo_wr, !fifo_stat.full, "queue overflow")
	`PCR_ASSERT_IMP(a_fifo_no_underflow, clk, arst_n, back_pop, !fifo_stat.empty, "queue underflow")
	// front only backs up into the input when the queue is full
	`PCR_ASSERT_IMP(a_stall_cause, clk, arst_n, !in_ready, fifo_stat.full, "stall without full queue")
	`PCR_ASSERT_NEXT(a_cfg_write, clk, arst_n, cfg_wr_en, dt_step_q == $past(cfg_wr_data), "dt write lost")

endmodule
`default_nettype wire
